// ===== hdl/tmca_pkg.sv =====
package tmca_pkg;

  localparam int NUM_BARS = 16;

  localparam int BAR_W   = 4;
  localparam int R_W     = 18;
  localparam int SUM_W   = 48;
  localparam int ACC_W   = 64;
  localparam int CNT_W   = 32;
  localparam int NUM_FAM = 3;

  localparam int HIT_DEPTH  = 4 * NUM_BARS;
  localparam int PL_DEPTH   = 3 * NUM_BARS;
  localparam int REF_DEPTH  = NUM_BARS;
  localparam int PAIR_DEPTH = 3 * NUM_BARS * NUM_BARS;

  localparam int HIT_AW  = $clog2(HIT_DEPTH);
  localparam int PL_AW   = $clog2(PL_DEPTH);
  localparam int REF_AW  = $clog2(REF_DEPTH);
  localparam int PAIR_AW = $clog2(PAIR_DEPTH);
  localparam int CLR_W   = PAIR_AW;

  localparam logic [15:0] SCALE_RESET = 16'd2186;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [4:0] BANK_EVENTS   = 5'd0;
  localparam logic [4:0] BANK_RR       = 5'd1;
  localparam logic [4:0] BANK_DTDT     = 5'd2;
  localparam logic [4:0] BANK_HITS     = 5'd3;
  localparam logic [4:0] BANK_DUDU     = 5'd4;
  localparam logic [4:0] BANK_RDT      = 5'd5;
  localparam logic [4:0] BANK_R_BAR    = 5'd6;
  localparam logic [4:0] BANK_R_REF    = 5'd7;
  localparam logic [4:0] BANK_RDU      = 5'd8;
  localparam logic [4:0] BANK_DT_BAR   = 5'd9;
  localparam logic [4:0] BANK_DT_REF   = 5'd10;
  localparam logic [4:0] BANK_DTDU     = 5'd11;
  localparam logic [4:0] BANK_PAIR1    = 5'd12;
  localparam logic [4:0] BANK_PAIR2    = 5'd13;
  localparam logic [4:0] BANK_PAIR3    = 5'd14;
  localparam logic [4:0] BANK_DU_BAR   = 5'd15;
  localparam logic [4:0] BANK_DU_REF   = 5'd16;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         layer;
    logic [BAR_W-1:0]   bar;
    logic [15:0]        path_len;
    logic signed [15:0] time_diff;
    logic signed [15:0] ampl_diff;
    logic [4:0]         read_bank;
    logic [9:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    logic               bad_address;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_PROD,
    ST_UPD
  } state_e;

  function automatic logic signed [ACC_W-1:0] sat_add64(logic signed [ACC_W-1:0] a,
                                                       logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add48(logic signed [SUM_W-1:0] a,
                                                       logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

endpackage

// ===== hdl/tof_timing_calib_moment_accumulator_unit.sv =====
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o     in_item_i  (tmca_pkg::in_item_t)
// out       output     out_valid_o / out_stall_i   out_item_o (tmca_pkg::out_item_t)
// cfg       input      cfg_we_i                    cfg_wdata_i
// each transaction passes capture, reduced-time multiply with memory read,
// moment products, saturating update and write-back; a read waits in update while out is stalled
// after reset a clearing pass over 3*NUM_BARS*NUM_BARS addresses (768) zeroes all memories,
// input stalled meanwhile
// a read result sits in the output register; the next transaction is taken while it waits
module tof_timing_calib_moment_accumulator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tmca_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tmca_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);

  localparam int NB   = tmca_pkg::NUM_BARS;
  localparam int SW   = tmca_pkg::SUM_W;
  localparam int CW   = tmca_pkg::CNT_W;
  localparam int RW   = tmca_pkg::R_W;
  localparam int ROWW = tmca_pkg::NUM_FAM * SW;

  tmca_pkg::state_e state_q, state_d;

  logic [15:0]              scale_q;
  logic [tmca_pkg::CLR_W-1:0] clr_cnt_q;
  tmca_pkg::in_item_t       item_q;
  logic [CW-1:0]            event_count_q;
  logic [tmca_pkg::BAR_W-1:0] ref_bar_q;
  logic signed [63:0]       scal_q [6];
  logic [RW-1:0]            r_q;
  logic signed [63:0]       prod_q [6];
  logic                     out_valid_q;
  tmca_pkg::out_item_t      out_q;

  logic                     accept;
  logic                     rd_en;
  logic                     upd_en;
  logic                     out_load;
  logic                     clearing;
  logic                     clr_last;

  logic [CW-1:0]            hit_mem  [tmca_pkg::HIT_DEPTH];
  logic [ROWW-1:0]          pl_mem   [tmca_pkg::PL_DEPTH];
  logic [ROWW-1:0]          ref_mem  [tmca_pkg::REF_DEPTH];
  logic [CW-1:0]            pair_mem [tmca_pkg::PAIR_DEPTH];
  logic [CW-1:0]            hit_rdata_q, pair_rdata_q;
  logic [ROWW-1:0]          pl_rdata_q, ref_rdata_q;

  logic [tmca_pkg::HIT_AW-1:0]  hit_addr;
  logic [tmca_pkg::PL_AW-1:0]   pl_addr;
  logic [tmca_pkg::REF_AW-1:0]  ref_addr;
  logic [tmca_pkg::PAIR_AW-1:0] pair_addr;
  logic [15:0] hit_t, pl_t, ref_t, pair_t;
  logic [15:0] idx16, bank16, layer16, bar16, refb16, li16;
  logic [tmca_pkg::BAR_W-1:0] ref_use;
  logic        bar_ok;
  logic        acc_layer;

  logic [CW-1:0]   hit_wdata, pair_wdata;
  logic [ROWW-1:0] pl_wdata, ref_wdata;
  logic            hit_we, pl_we, ref_we, pair_we;
  logic [tmca_pkg::HIT_AW-1:0]  hit_waddr;
  logic [tmca_pkg::PL_AW-1:0]   pl_waddr;
  logic [tmca_pkg::REF_AW-1:0]  ref_waddr;
  logic [tmca_pkg::PAIR_AW-1:0] pair_waddr;

  logic signed [SW-1:0] terms [3];
  logic [32:0]          r_full;
  logic signed [RW:0]   r_s;
  logic signed [2*RW+1:0] p_rr;
  logic signed [31:0]   p_tt, p_uu, p_tu;
  logic signed [RW+16:0] p_rt, p_ru;

  tmca_pkg::out_item_t  rd_res;

  // control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmca_pkg::ST_CLEAR: if (clr_last) state_d = tmca_pkg::ST_IDLE;
      tmca_pkg::ST_IDLE:  if (in_valid_i) state_d = tmca_pkg::ST_MUL;
      tmca_pkg::ST_MUL:   state_d = tmca_pkg::ST_PROD;
      tmca_pkg::ST_PROD:  state_d = tmca_pkg::ST_UPD;
      tmca_pkg::ST_UPD: begin
        if (item_q.opcode == tmca_pkg::OP_ACC || !out_valid_q || !out_stall_i) begin
          state_d = tmca_pkg::ST_IDLE;
        end
      end
      default: state_d = tmca_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != tmca_pkg::ST_IDLE);
    clearing   = (state_q == tmca_pkg::ST_CLEAR);
    rd_en      = (state_q == tmca_pkg::ST_MUL);
    upd_en     = (state_q == tmca_pkg::ST_UPD) && (item_q.opcode == tmca_pkg::OP_ACC);
    out_load   = (state_q == tmca_pkg::ST_UPD) && (item_q.opcode == tmca_pkg::OP_READ) &&
                 (!out_valid_q || !out_stall_i);
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign clr_last = (clr_cnt_q == tmca_pkg::CLR_W'(tmca_pkg::PAIR_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tmca_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      scale_q   <= tmca_pkg::SCALE_RESET;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + tmca_pkg::CLR_W'(1);
      if (cfg_we_i) scale_q <= cfg_wdata_i;
    end
  end

  // addresses
  always_comb begin
    idx16   = 16'(item_q.read_index);
    bank16  = 16'(item_q.read_bank);
    layer16 = 16'(item_q.layer);
    bar16   = 16'(item_q.bar);
    ref_use = (16'(ref_bar_q) < 16'(NB)) ? ref_bar_q : '0;
    refb16  = 16'(ref_use);
    li16    = layer16 - 16'd1;
    bar_ok  = bar16 < 16'(NB);
    acc_layer = (item_q.layer != 2'd0);
    if (item_q.opcode == tmca_pkg::OP_READ) begin
      hit_t  = idx16;
      pl_t   = idx16;
      ref_t  = idx16;
      pair_t = (bank16 - 16'(tmca_pkg::BANK_PAIR1)) * 16'(NB * NB) + idx16;
    end else begin
      hit_t  = layer16 * 16'(NB) + bar16;
      pl_t   = li16 * 16'(NB) + bar16;
      ref_t  = refb16;
      pair_t = (li16 * 16'(NB) + refb16) * 16'(NB) + bar16;
    end
    hit_addr  = hit_t[tmca_pkg::HIT_AW-1:0];
    pl_addr   = pl_t[tmca_pkg::PL_AW-1:0];
    ref_addr  = ref_t[tmca_pkg::REF_AW-1:0];
    pair_addr = pair_t[tmca_pkg::PAIR_AW-1:0];
  end

  // datapath
  always_comb begin
    r_full = 33'(item_q.path_len) * 33'(scale_q) + 33'd8192;
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    if (rd_en) r_q <= r_full[RW+13:14];
    if (state_q == tmca_pkg::ST_PROD) begin
      prod_q[0] <= 64'(p_rr);
      prod_q[1] <= 64'(p_tt);
      prod_q[2] <= 64'(p_uu);
      prod_q[3] <= 64'(p_rt);
      prod_q[4] <= 64'(p_ru);
      prod_q[5] <= 64'(p_tu);
    end
  end

  always_comb begin
    r_s  = signed'({1'b0, r_q});
    p_rr = r_s * r_s;
    p_tt = item_q.time_diff * item_q.time_diff;
    p_uu = item_q.ampl_diff * item_q.ampl_diff;
    p_tu = item_q.time_diff * item_q.ampl_diff;
    p_rt = (RW+17)'(r_s) * (RW+17)'(item_q.time_diff);
    p_ru = (RW+17)'(r_s) * (RW+17)'(item_q.ampl_diff);
    terms[0] = SW'(r_s);
    terms[1] = SW'(item_q.time_diff);
    terms[2] = SW'(item_q.ampl_diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_count_q <= '0;
      ref_bar_q     <= '0;
      for (int k = 0; k < 6; k++) scal_q[k] <= '0;
    end else if (upd_en && bar_ok) begin
      if (!acc_layer) begin
        event_count_q <= tmca_pkg::count_up(event_count_q);
        ref_bar_q     <= item_q.bar;
      end else begin
        for (int k = 0; k < 6; k++) scal_q[k] <= tmca_pkg::sat_add64(scal_q[k], prod_q[k]);
      end
    end
  end

  // memory write side
  always_comb begin
    hit_wdata  = clearing ? '0 : tmca_pkg::count_up(hit_rdata_q);
    pair_wdata = clearing ? '0 : tmca_pkg::count_up(pair_rdata_q);
    for (int f = 0; f < tmca_pkg::NUM_FAM; f++) begin
      pl_wdata[f*SW +: SW]  = clearing ? '0 :
          tmca_pkg::sat_add48(signed'(pl_rdata_q[f*SW +: SW]), terms[f]);
      ref_wdata[f*SW +: SW] = clearing ? '0 :
          tmca_pkg::sat_add48(signed'(ref_rdata_q[f*SW +: SW]), terms[f]);
    end
    hit_we  = clearing ? (clr_cnt_q < tmca_pkg::CLR_W'(tmca_pkg::HIT_DEPTH)) : (upd_en && bar_ok);
    pl_we   = clearing ? (clr_cnt_q < tmca_pkg::CLR_W'(tmca_pkg::PL_DEPTH)) :
                         (upd_en && bar_ok && acc_layer);
    ref_we  = clearing ? (clr_cnt_q < tmca_pkg::CLR_W'(tmca_pkg::REF_DEPTH)) :
                         (upd_en && bar_ok && acc_layer);
    pair_we = clearing ? 1'b1 : (upd_en && bar_ok && acc_layer);
    hit_waddr  = clearing ? clr_cnt_q[tmca_pkg::HIT_AW-1:0] : hit_addr;
    pl_waddr   = clearing ? clr_cnt_q[tmca_pkg::PL_AW-1:0] : pl_addr;
    ref_waddr  = clearing ? clr_cnt_q[tmca_pkg::REF_AW-1:0] : ref_addr;
    pair_waddr = clearing ? clr_cnt_q[tmca_pkg::PAIR_AW-1:0] : pair_addr;
  end

  always_ff @(posedge clk_i) begin
    if (hit_we) hit_mem[hit_waddr] <= hit_wdata;
    if (rd_en) hit_rdata_q <= hit_mem[hit_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) pl_mem[pl_waddr] <= pl_wdata;
    if (rd_en) pl_rdata_q <= pl_mem[pl_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (rd_en) ref_rdata_q <= ref_mem[ref_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
    if (rd_en) pair_rdata_q <= pair_mem[pair_addr];
  end

  // read result
  always_comb begin
    rd_res.read_value  = '0;
    rd_res.bad_address = 1'b0;
    unique case (item_q.read_bank)
      tmca_pkg::BANK_EVENTS: begin
        rd_res.read_value = 64'(event_count_q);
        rd_res.bad_address = (idx16 != 16'd0);
      end
      tmca_pkg::BANK_RR: begin
        rd_res.read_value = scal_q[0];
        rd_res.bad_address = (idx16 != 16'd0);
      end
      tmca_pkg::BANK_DTDT: begin
        rd_res.read_value = scal_q[1];
        rd_res.bad_address = (idx16 != 16'd0);
      end
      tmca_pkg::BANK_DUDU: begin
        rd_res.read_value = scal_q[2];
        rd_res.bad_address = (idx16 != 16'd0);
      end
      tmca_pkg::BANK_RDT: begin
        rd_res.read_value = scal_q[3];
        rd_res.bad_address = (idx16 != 16'd0);
      end
      tmca_pkg::BANK_RDU: begin
        rd_res.read_value = scal_q[4];
        rd_res.bad_address = (idx16 != 16'd0);
      end
      tmca_pkg::BANK_DTDU: begin
        rd_res.read_value = scal_q[5];
        rd_res.bad_address = (idx16 != 16'd0);
      end
      tmca_pkg::BANK_HITS: begin
        rd_res.read_value = 64'(hit_rdata_q);
        rd_res.bad_address = (idx16 >= 16'(tmca_pkg::HIT_DEPTH));
      end
      tmca_pkg::BANK_R_BAR: begin
        rd_res.read_value = 64'(signed'(pl_rdata_q[0*SW +: SW]));
        rd_res.bad_address = (idx16 >= 16'(tmca_pkg::PL_DEPTH));
      end
      tmca_pkg::BANK_DT_BAR: begin
        rd_res.read_value = 64'(signed'(pl_rdata_q[1*SW +: SW]));
        rd_res.bad_address = (idx16 >= 16'(tmca_pkg::PL_DEPTH));
      end
      tmca_pkg::BANK_DU_BAR: begin
        rd_res.read_value = 64'(signed'(pl_rdata_q[2*SW +: SW]));
        rd_res.bad_address = (idx16 >= 16'(tmca_pkg::PL_DEPTH));
      end
      tmca_pkg::BANK_R_REF: begin
        rd_res.read_value = 64'(signed'(ref_rdata_q[0*SW +: SW]));
        rd_res.bad_address = (idx16 >= 16'(tmca_pkg::REF_DEPTH));
      end
      tmca_pkg::BANK_DT_REF: begin
        rd_res.read_value = 64'(signed'(ref_rdata_q[1*SW +: SW]));
        rd_res.bad_address = (idx16 >= 16'(tmca_pkg::REF_DEPTH));
      end
      tmca_pkg::BANK_DU_REF: begin
        rd_res.read_value = 64'(signed'(ref_rdata_q[2*SW +: SW]));
        rd_res.bad_address = (idx16 >= 16'(tmca_pkg::REF_DEPTH));
      end
      tmca_pkg::BANK_PAIR1, tmca_pkg::BANK_PAIR2, tmca_pkg::BANK_PAIR3: begin
        rd_res.read_value = 64'(pair_rdata_q);
        rd_res.bad_address = (idx16 >= 16'(NB * NB));
      end
      default: rd_res.bad_address = 1'b1;
    endcase
    if (rd_res.bad_address) rd_res.read_value = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= rd_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/tmca_checker.sv =====
module tmca_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input tmca_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tmca_pkg::out_item_t out_item_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted while busy");

  // bad address gives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_address |-> out_item_o.read_value == 64'd0)
    else $error("bad address with non-zero value");

  // accumulate gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.opcode == tmca_pkg::OP_ACC
    |=> ##3 !$rose(out_valid_o))
    else $error("result from accumulate transaction");

endmodule

bind tof_timing_calib_moment_accumulator_unit tmca_checker u_tmca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

class moment_scoreboard;
  int unsigned scale;
  int unsigned event_count;
  int unsigned reference_bar;
  longint scalar_sums[6];
  int unsigned layer_hits[tmca_pkg::HIT_DEPTH];
  longint layer_sums[3][tmca_pkg::PL_DEPTH];
  longint ref_sums[3][tmca_pkg::REF_DEPTH];
  int unsigned pair_hits[tmca_pkg::PAIR_DEPTH];
  tmca_pkg::out_item_t pending_reads[$];
  int errors;
  int reads_checked;
  int accumulates;

  function new();
    scale = tmca_pkg::SCALE_RESET;
    event_count = 0;
    reference_bar = 0;
    errors = 0;
    reads_checked = 0;
    accumulates = 0;
    foreach (scalar_sums[k]) scalar_sums[k] = 0;
    foreach (layer_hits[k]) layer_hits[k] = 0;
    foreach (layer_sums[f, k]) layer_sums[f][k] = 0;
    foreach (ref_sums[f, k]) ref_sums[f][k] = 0;
    foreach (pair_hits[k]) pair_hits[k] = 0;
  endfunction

  function longint clamp_add(longint a, longint b, int w);
    longint hi, lo;
    hi = (w == 64) ? 64'h7fff_ffff_ffff_ffff : ((64'sd1 <<< (w - 1)) - 1);
    lo = -hi - 1;
    if (b > 0 && a > hi - b) return hi;
    if (b < 0 && a < lo - b) return lo;
    return a + b;
  endfunction

  function int unsigned bump(int unsigned c);
    return (c == 32'hffff_ffff) ? c : c + 1;
  endfunction

  function void note_input(tmca_pkg::in_item_t it);
    longint r, dt, du, prods[6], terms[3];
    longint unsigned rp;
    int li, b;
    tmca_pkg::out_item_t res;
    int bank, idx;
    if (it.opcode == tmca_pkg::OP_ACC) begin
      accumulates++;
      b = it.bar;
      if (it.layer == 0) begin
        event_count = bump(event_count);
        reference_bar = b;
        layer_hits[b] = bump(layer_hits[b]);
        return;
      end
      rp = (longint'(it.path_len) * longint'(scale) + 8192) >> 14;
      r = rp;
      dt = it.time_diff;
      du = it.ampl_diff;
      prods[0] = r * r; prods[1] = dt * dt; prods[2] = du * du;
      prods[3] = r * dt; prods[4] = r * du; prods[5] = dt * du;
      foreach (prods[k]) scalar_sums[k] = clamp_add(scalar_sums[k], prods[k], 64);
      layer_hits[it.layer * tmca_pkg::NUM_BARS + b] =
        bump(layer_hits[it.layer * tmca_pkg::NUM_BARS + b]);
      li = it.layer - 1;
      terms[0] = r; terms[1] = dt; terms[2] = du;
      for (int f = 0; f < 3; f++) begin
        layer_sums[f][li * tmca_pkg::NUM_BARS + b] =
          clamp_add(layer_sums[f][li * tmca_pkg::NUM_BARS + b], terms[f], 48);
        ref_sums[f][reference_bar] = clamp_add(ref_sums[f][reference_bar], terms[f], 48);
      end
      idx = (li * tmca_pkg::NUM_BARS + reference_bar) * tmca_pkg::NUM_BARS + b;
      pair_hits[idx] = bump(pair_hits[idx]);
      return;
    end
    bank = it.read_bank;
    idx = it.read_index;
    res.read_value = 0;
    res.bad_address = 1'b1;
    case (it.read_bank)
      tmca_pkg::BANK_EVENTS: if (idx == 0) begin
        res.read_value = 64'(event_count); res.bad_address = 0;
      end
      tmca_pkg::BANK_RR, tmca_pkg::BANK_DTDT, tmca_pkg::BANK_DUDU,
      tmca_pkg::BANK_RDT, tmca_pkg::BANK_RDU, tmca_pkg::BANK_DTDU: if (idx == 0) begin
        res.bad_address = 0;
        case (it.read_bank)
          tmca_pkg::BANK_RR:   res.read_value = scalar_sums[0];
          tmca_pkg::BANK_DTDT: res.read_value = scalar_sums[1];
          tmca_pkg::BANK_DUDU: res.read_value = scalar_sums[2];
          tmca_pkg::BANK_RDT:  res.read_value = scalar_sums[3];
          tmca_pkg::BANK_RDU:  res.read_value = scalar_sums[4];
          default:             res.read_value = scalar_sums[5];
        endcase
      end
      tmca_pkg::BANK_HITS: if (idx < tmca_pkg::HIT_DEPTH) begin
        res.read_value = 64'(layer_hits[idx]); res.bad_address = 0;
      end
      tmca_pkg::BANK_R_BAR: if (idx < tmca_pkg::PL_DEPTH) begin
        res.read_value = layer_sums[0][idx]; res.bad_address = 0;
      end
      tmca_pkg::BANK_DT_BAR: if (idx < tmca_pkg::PL_DEPTH) begin
        res.read_value = layer_sums[1][idx]; res.bad_address = 0;
      end
      tmca_pkg::BANK_DU_BAR: if (idx < tmca_pkg::PL_DEPTH) begin
        res.read_value = layer_sums[2][idx]; res.bad_address = 0;
      end
      tmca_pkg::BANK_R_REF: if (idx < tmca_pkg::REF_DEPTH) begin
        res.read_value = ref_sums[0][idx]; res.bad_address = 0;
      end
      tmca_pkg::BANK_DT_REF: if (idx < tmca_pkg::REF_DEPTH) begin
        res.read_value = ref_sums[1][idx]; res.bad_address = 0;
      end
      tmca_pkg::BANK_DU_REF: if (idx < tmca_pkg::REF_DEPTH) begin
        res.read_value = ref_sums[2][idx]; res.bad_address = 0;
      end
      tmca_pkg::BANK_PAIR1, tmca_pkg::BANK_PAIR2, tmca_pkg::BANK_PAIR3:
        if (idx < tmca_pkg::NUM_BARS * tmca_pkg::NUM_BARS) begin
          res.read_value = 64'(pair_hits[(bank - tmca_pkg::BANK_PAIR1) *
                                         tmca_pkg::NUM_BARS * tmca_pkg::NUM_BARS + idx]);
          res.bad_address = 0;
        end
      default: ;
    endcase
    pending_reads.push_back(res);
  endfunction

  function void check_result(tmca_pkg::out_item_t got);
    tmca_pkg::out_item_t exp;
    if (pending_reads.size() == 0) begin
      $error("unexpected result value=%0d bad=%0b", got.read_value, got.bad_address);
      errors++;
      return;
    end
    exp = pending_reads.pop_front();
    reads_checked++;
    if (got.read_value !== exp.read_value) begin
      $error("read_value expected %0d actual %0d", exp.read_value, got.read_value);
      errors++;
    end
    if (got.bad_address !== exp.bad_address) begin
      $error("bad_address expected %0b actual %0b", exp.bad_address, got.bad_address);
      errors++;
    end
  endfunction
endclass

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tmca_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tmca_pkg::out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  moment_scoreboard board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;
  int errors_total;

  always #10 clk_i = ~clk_i;

  tof_timing_calib_moment_accumulator_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // result side: random stall plus long hold-off; also checks results and notes accepted inputs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_item_o);
      if (in_valid_i && !in_stall_o) board.note_input(in_item_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (quiet_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(tmca_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic tmca_pkg::in_item_t hit_item(logic [1:0] lay, logic [3:0] b);
    tmca_pkg::in_item_t it;
    it = tmca_pkg::in_item_t'(($bits(tmca_pkg::in_item_t))'({$urandom, $urandom, $urandom}));
    it.opcode = tmca_pkg::OP_ACC;
    it.layer = lay;
    it.bar = b;
    case ($urandom_range(5))
      0: it.path_len = 16'hffff;
      1: it.path_len = 16'h0000;
      default: ;
    endcase
    case ($urandom_range(5))
      0: begin it.time_diff = 16'sh8000; it.ampl_diff = 16'sh8000; end
      1: begin it.time_diff = 16'sh7fff; it.ampl_diff = 16'sh7fff; end
      default: ;
    endcase
    return it;
  endfunction

  function automatic tmca_pkg::in_item_t read_item(logic [4:0] bank, logic [9:0] idx);
    tmca_pkg::in_item_t it;
    it = tmca_pkg::in_item_t'(($bits(tmca_pkg::in_item_t))'({$urandom, $urandom, $urandom}));
    it.opcode = tmca_pkg::OP_READ;
    it.read_bank = bank;
    it.read_index = idx;
    return it;
  endfunction

  function automatic tmca_pkg::in_item_t random_read();
    logic [4:0] bank;
    logic [9:0] idx;
    bank = 5'($urandom_range(16));
    case ($urandom_range(7))
      0: idx = 10'($urandom);
      1: bank = 5'($urandom);
      2: idx = '0;
      default: idx = 10'($urandom_range(tmca_pkg::NUM_BARS * tmca_pkg::NUM_BARS - 1));
    endcase
    if (bank inside {tmca_pkg::BANK_EVENTS, tmca_pkg::BANK_RR, tmca_pkg::BANK_DTDT,
                     tmca_pkg::BANK_DUDU, tmca_pkg::BANK_RDT, tmca_pkg::BANK_RDU,
                     tmca_pkg::BANK_DTDU} && $urandom_range(3) != 0)
      idx = '0;
    return read_item(bank, idx);
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    while (board.pending_reads.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.scale = v;
  endtask

  task automatic random_phase(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 7) begin
        send(hit_item(2'd0, 4'($urandom)));
        for (int l = 1; l < 4; l++) send(hit_item(l[1:0], 4'($urandom)));
        sent += 4;
      end else if ($urandom_range(1)) begin
        send(hit_item(2'($urandom), 4'($urandom)));
        sent++;
      end
      send(random_read());
      sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, layer without event start, every bank, bad addresses
    send(hit_item(2'd2, 4'd15));
    send(hit_item(2'd0, 4'd15));
    send(hit_item(2'd1, 4'd0));
    send(hit_item(2'd3, 4'd15));
    send(hit_item(2'd3, 4'd15));
    for (int b = 0; b <= 16; b++) send(read_item(b[4:0], 10'd0));
    send(read_item(tmca_pkg::BANK_PAIR3, 10'd255));
    send(read_item(tmca_pkg::BANK_R_BAR, 10'd47));
    send(read_item(tmca_pkg::BANK_HITS, 10'd64));
    send(read_item(5'd31, 10'd0));
    send(read_item(tmca_pkg::BANK_RR, 10'd1023));

    write_scale(16'hffff);
    send_idle_pct = 31; recv_idle_pct = 83;
    random_phase(450);

    write_scale(16'h0000);
    send_idle_pct = 83; recv_idle_pct = 31;
    random_phase(300);

    // long hold-off so the block backs up onto its input
    write_scale(16'($urandom));
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(60);
    join

    write_scale(tmca_pkg::SCALE_RESET);
    random_phase(450);

    drain();
    repeat (20) @(posedge clk_i);
    errors_total = board.errors + board.pending_reads.size();
    $display("covered %0d accumulate and %0d checked read transactions over 5 scale settings",
             board.accumulates, board.reads_checked);
    if (errors_total == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
